// ===== rtl/te_hist_pkg.sv =====
// Package with the types and constants of the transfer entropy histogram unit.
`default_nettype none
package te_hist_pkg;
    localparam int SYMBOL_BITS_DEF   = 1;
    localparam int WINDOW_MAX_DEF    = 4;
    localparam int MAX_LENGTH_DEF    = 65536;
    localparam int LOG_FRAC_BITS_DEF = 16;
    localparam int TE_W    = 21;
    localparam int N_W     = 17;
    localparam int CFG_W   = 3;
    localparam int SUM_W   = 64;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_LOG,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } te_state_t;
endpackage
`default_nettype wire

// ===== rtl/te_hist_if.sv =====
// Valid/ready channel interfaces for the input and result items.
`default_nettype none
interface te_in_if #(parameter int SYMBOL_BITS = 1);
    logic                   valid;
    logic                   ready;
    logic [SYMBOL_BITS-1:0] x_symbol;
    logic [SYMBOL_BITS-1:0] y_symbol;
    logic                   last_sample;
    modport source (output valid, x_symbol, y_symbol, last_sample, input ready);
    modport sink (input valid, x_symbol, y_symbol, last_sample, output ready);
endinterface

interface te_out_if;
    logic               valid;
    logic               ready;
    logic signed [20:0] transfer_entropy;
    logic               too_short;
    logic [16:0]        window_total;
    modport source (output valid, transfer_entropy, too_short, window_total, input ready);
    modport sink (input valid, transfer_entropy, too_short, window_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/transfer_entropy_histogram_unit.sv =====
// Top level of the transfer entropy histogram unit.
// Items (x, y, last) are accepted one at a time; ready is low while an item is at
// work. A plain item is accepted, its counts are read, and then the four count
// memories get a read-modify-write; the write is skipped while the first window is
// still filling. After reset, and after every result, a clearing pass over all
// 2^((2*WINDOW_MAX+1)*SYMBOL_BITS) joint entries (512 by default) empties the
// memories before the next item is taken. After a last item the unit walks every
// joint entry unless the stream was too short: an entry with any zero count is
// skipped, and each other entry goes through the one shared log2 squaring unit. A
// restoring divider then produces the result. window_size may be written only while the block is idle.
`default_nettype none
module transfer_entropy_histogram_unit
    import te_hist_pkg::*;
#(
    parameter int SYMBOL_BITS   = SYMBOL_BITS_DEF,
    parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
    parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
    parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    te_in_if.sink                 in_ch,
    te_out_if.source              out_ch
);
    localparam int HB  = WINDOW_MAX * SYMBOL_BITS;
    localparam int JB  = 2 * HB + SYMBOL_BITS;
    localparam int PB  = 2 * HB;
    localparam int TB  = HB + SYMBOL_BITS;
    localparam int CW  = $clog2(MAX_LENGTH + 1);
    localparam int LW  = LOG_FRAC_BITS + 5;
    localparam int WW  = $clog2(WINDOW_MAX + 1);
    localparam int FC  = $clog2(LOG_FRAC_BITS + 1);
    localparam int DC  = $clog2(SUM_W + 2);

    te_state_t state_reg, state_next;

    logic [CFG_W-1:0] window_reg;
    logic [HB-1:0]    xh_reg, yh_reg;
    logic [CW-1:0]    cnt_reg;
    logic [JB:0]      addr_reg;
    logic             last_reg;
    logic [SYMBOL_BITS-1:0] ys_reg;
    logic [SYMBOL_BITS-1:0] xs_hold;

    logic [CW-1:0] joint_mem [0:(1<<JB)-1];
    logic [CW-1:0] pair_mem  [0:(1<<PB)-1];
    logic [CW-1:0] tgt_mem   [0:(1<<TB)-1];
    logic [CW-1:0] py_mem    [0:(1<<HB)-1];
    logic [CW-1:0] jrd_reg, prd_reg, trd_reg, yrd_reg;

    // Effective window and the indices it produces.
    logic [WW-1:0] w_eff;
    always_comb
    begin
        if (window_reg == '0)
            w_eff = WW'(1);
        else if (32'(window_reg) > WINDOW_MAX)
            w_eff = WW'(WINDOW_MAX);
        else
            w_eff = WW'(window_reg);
    end

    logic [HB-1:0] wmask, xh_m, yh_m;
    logic [PB-1:0] pp_cur;
    always_comb
    begin
        wmask  = HB'(({(HB+1){1'b1}} << (32'(w_eff) * SYMBOL_BITS)) ^ {(HB+1){1'b1}});
        xh_m   = xh_reg & wmask;
        yh_m   = yh_reg & wmask;
        pp_cur = PB'(({{HB{1'b0}}, xh_m} << (32'(w_eff) * SYMBOL_BITS)) | PB'(yh_m));
    end

    // Walk decoding from the joint address.
    logic [JB-1:0]          widx;
    logic [PB-1:0]          wpp;
    logic [SYMBOL_BITS-1:0] wyn;
    logic [HB-1:0]          wyh;
    always_comb
    begin
        widx = addr_reg[JB-1:0];
        wpp  = widx[JB-1:SYMBOL_BITS];
        wyn  = widx[SYMBOL_BITS-1:0];
        wyh  = HB'(wpp) & wmask;
    end

    // Memory addresses, chosen by state.
    logic [JB-1:0] ja;
    logic [PB-1:0] pa;
    logic [TB-1:0] ta;
    logic [HB-1:0] ya;
    always_comb
    begin
        ja = {pp_cur, ys_reg};
        pa = pp_cur;
        ta = {yh_m, ys_reg};
        ya = yh_m;
        if (state_reg == ST_CLEAR)
        begin
            ja = widx;
            pa = PB'(widx);
            ta = TB'(widx);
            ya = HB'(widx);
        end
        else if (state_reg == ST_WALK_RD || state_reg == ST_WALK_CHK ||
                 state_reg == ST_LOG || state_reg == ST_ACC)
        begin
            ja = widx;
            pa = wpp;
            ta = {wyh, wyn};
            ya = wyh;
        end
    end

    logic clr_we, load_we, fin_we;
    always_comb
    begin
        clr_we  = (state_reg == ST_CLEAR);
        load_we = (state_reg == ST_LOAD_WR);
        fin_we  = (state_reg == ST_FIN_WR);
    end

    always_ff @(posedge clk)
    begin
        jrd_reg <= joint_mem[ja];
        prd_reg <= pair_mem[pa];
        trd_reg <= tgt_mem[ta];
        yrd_reg <= py_mem[ya];
        if (clr_we)
        begin
            joint_mem[ja] <= '0;
            if (addr_reg[JB-1:0] < JB'(1 << PB)) pair_mem[pa] <= '0;
            if (addr_reg[JB-1:0] < JB'(1 << TB)) tgt_mem[ta] <= '0;
            if (addr_reg[JB-1:0] < JB'(1 << HB)) py_mem[ya] <= '0;
        end
        else if (load_we)
        begin
            joint_mem[ja] <= jrd_reg + CW'(1);
            pair_mem[pa]  <= prd_reg + CW'(1);
            tgt_mem[ta]   <= trd_reg + CW'(1);
            py_mem[ya]    <= yrd_reg + CW'(1);
        end
        else if (fin_we)
        begin
            pair_mem[pa] <= prd_reg + CW'(1);
            py_mem[ya]   <= yrd_reg + CW'(1);
        end
    end

    // Shared log2 unit: one squaring step per cycle.
    logic [1:0]             lsel_reg;
    logic [CW-1:0]          lop;
    logic [4:0]             le_next;
    logic [32:0]            lm_reg, lm_next;
    logic [FC-1:0]          lk_reg;
    logic [LOG_FRAC_BITS-1:0] lf_reg;
    logic                   lbusy_reg;
    logic [4:0]             le_reg;
    logic [65:0]            lsq;
    logic [65:0]            lsh;
    logic signed [LW:0]     dacc_reg;
    logic [LW-1:0]          lval;

    always_comb
    begin
        unique case (lsel_reg)
            2'd0:    lop = jrd_reg;
            2'd1:    lop = prd_reg;
            2'd2:    lop = trd_reg;
            default: lop = yrd_reg;
        endcase
        le_next = '0;
        for (int i = 1; i < CW; i++)
            if (lop[i]) le_next = 5'(i);
        lm_next = 33'({1'b0, 32'(lop)} << (5'd31 - le_next));
        lsq     = 66'(lm_reg) * 66'(lm_reg);
        lsh     = lsq >> 31;
        lval    = LW'({le_reg, lf_reg});
    end

    // Accumulator, divider and result.
    logic signed [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0]        dq_reg, drem_reg, ddiv;
    logic [DC-1:0]           dcnt_reg;
    logic [N_W-1:0]          n_reg;
    logic [N_W-1:0]          total_reg;
    logic [SUM_W:0]          dtrial;
    logic                    neg_reg;
    logic signed [TE_W-1:0]  te_reg;
    logic                    short_reg;
    logic                    ovalid_reg;
    logic signed [CW+LW+1:0] prod;

    always_comb
    begin
        if (LOG_FRAC_BITS >= 16)
            ddiv = SUM_W'(n_reg) << (LOG_FRAC_BITS >= 16 ? LOG_FRAC_BITS - 16 : 0);
        else
            ddiv = SUM_W'(n_reg);
        dtrial = {drem_reg, dq_reg[SUM_W-1]} - {1'b0, ddiv};
        prod   = $signed({1'b0, jrd_reg}) * dacc_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (widx == '1) state_next = ST_IDLE;
            ST_IDLE:     if (in_ch.valid) state_next = ST_LOAD_RD;
            ST_LOAD_RD:
            begin
                if (cnt_reg < CW'(MAX_LENGTH) && cnt_reg >= CW'(w_eff))
                    state_next = ST_LOAD_WR;
                else if (last_reg)
                    state_next = ST_FIN_RD;
                else
                    state_next = ST_IDLE;
            end
            ST_LOAD_WR:  state_next = last_reg ? ST_FIN_RD : ST_IDLE;
            ST_FIN_RD:   state_next = (cnt_reg < CW'(w_eff)) ? ST_OUT : ST_FIN_WR;
            ST_FIN_WR:   state_next = ST_WALK_RD;
            ST_WALK_RD:  state_next = ST_WALK_CHK;
            ST_WALK_CHK:
            begin
                if (addr_reg[JB])
                    state_next = ST_DIV;
                else if (jrd_reg != '0 && prd_reg != '0 && trd_reg != '0 && yrd_reg != '0)
                    state_next = ST_LOG;
                else
                    state_next = ST_WALK_RD;
            end
            ST_LOG:
            begin
                if (lbusy_reg && lk_reg == FC'(LOG_FRAC_BITS) && lsel_reg == 2'd3)
                    state_next = ST_ACC;
            end
            ST_ACC:      state_next = addr_reg[JB] ? ST_DIV : ST_WALK_RD;
            ST_DIV:      if (dcnt_reg == '0) state_next = ST_OUT;
            ST_OUT:      if (out_ch.ready || !ovalid_reg) state_next = ST_CLEAR;
            default:     state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= CFG_W'(1);
            xh_reg     <= '0;
            yh_reg     <= '0;
            cnt_reg    <= '0;
            addr_reg   <= '0;
            last_reg   <= 1'b0;
            ys_reg     <= '0;
            lsel_reg   <= '0;
            lbusy_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            sum_reg    <= '0;
            dcnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we) window_reg <= cfg_wdata;
            if (out_ch.ready && state_reg != ST_OUT) ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    addr_reg <= (widx == '1) ? '0 : addr_reg + (JB+1)'(1);
                    xh_reg   <= '0;
                    yh_reg   <= '0;
                    cnt_reg  <= '0;
                    sum_reg  <= '0;
                end
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        // History shifts only after the reads are addressed.
                        last_reg <= in_ch.last_sample;
                        ys_reg   <= in_ch.y_symbol;
                    end
                end
                ST_LOAD_RD:
                begin
                    if (cnt_reg < CW'(MAX_LENGTH) && cnt_reg < CW'(w_eff))
                    begin
                        xh_reg  <= (xh_reg << SYMBOL_BITS) | HB'(xs_hold);
                        yh_reg  <= (yh_reg << SYMBOL_BITS) | HB'(ys_reg);
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_LOAD_WR:
                begin
                    xh_reg  <= (xh_reg << SYMBOL_BITS) | HB'(xs_hold);
                    yh_reg  <= (yh_reg << SYMBOL_BITS) | HB'(ys_reg);
                    cnt_reg <= cnt_reg + CW'(1);
                end
                ST_FIN_RD:
                begin
                    n_reg    <= N_W'(cnt_reg - CW'(w_eff));
                    addr_reg <= '0;
                    sum_reg  <= '0;
                end
                ST_WALK_CHK:
                begin
                    lsel_reg <= '0;
                    lbusy_reg <= 1'b0;
                    dacc_reg <= '0;
                    if (!(jrd_reg != '0 && prd_reg != '0 && trd_reg != '0 && yrd_reg != '0))
                        addr_reg <= addr_reg + (JB+1)'(1);
                    if (addr_reg[JB]) dcnt_reg <= DC'(SUM_W + 1);
                end
                ST_LOG:
                begin
                    if (!lbusy_reg)
                    begin
                        lbusy_reg <= 1'b1;
                        le_reg    <= le_next;
                        lm_reg    <= lm_next;
                        lk_reg    <= '0;
                        lf_reg    <= '0;
                    end
                    else if (lk_reg != FC'(LOG_FRAC_BITS))
                    begin
                        lk_reg <= lk_reg + FC'(1);
                        if (lsh[32])
                        begin
                            lf_reg <= (lf_reg << 1) | LOG_FRAC_BITS'(1);
                            lm_reg <= 33'(lsh >> 1);
                        end
                        else
                        begin
                            lf_reg <= lf_reg << 1;
                            lm_reg <= 33'(lsh);
                        end
                    end
                    else
                    begin
                        lbusy_reg <= 1'b0;
                        lsel_reg  <= lsel_reg + 2'd1;
                        if (lsel_reg == 2'd0 || lsel_reg == 2'd3)
                            dacc_reg <= dacc_reg + $signed({1'b0, lval});
                        else
                            dacc_reg <= dacc_reg - $signed({1'b0, lval});
                    end
                end
                ST_ACC:
                begin
                    sum_reg  <= sum_reg + SUM_W'(prod);
                    addr_reg <= addr_reg + (JB+1)'(1);
                    if (addr_reg[JB]) dcnt_reg <= DC'(SUM_W + 1);
                end
                ST_DIV:
                begin
                    if (dcnt_reg == DC'(SUM_W + 1))
                    begin
                        neg_reg  <= sum_reg[SUM_W-1];
                        if (LOG_FRAC_BITS < 16)
                            dq_reg <= (sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg))
                                      << (LOG_FRAC_BITS < 16 ? 16 - LOG_FRAC_BITS : 0);
                        else
                            dq_reg <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                        drem_reg <= '0;
                        dcnt_reg <= dcnt_reg - DC'(1);
                    end
                    else if (dcnt_reg != '0)
                    begin
                        dcnt_reg <= dcnt_reg - DC'(1);
                        if (!dtrial[SUM_W])
                        begin
                            drem_reg <= dtrial[SUM_W-1:0];
                            dq_reg   <= {dq_reg[SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= {drem_reg[SUM_W-2:0], dq_reg[SUM_W-1]};
                            dq_reg   <= {dq_reg[SUM_W-2:0], 1'b0};
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        ovalid_reg <= 1'b1;
                        addr_reg   <= '0;
                        if (cnt_reg < CW'(w_eff))
                        begin
                            te_reg    <= '0;
                            short_reg <= 1'b1;
                            total_reg <= '0;
                        end
                        else
                        begin
                            short_reg <= 1'b0;
                            total_reg <= n_reg;
                            if (n_reg == '0)
                                te_reg <= '0;
                            else if (neg_reg)
                                te_reg <= (dq_reg > SUM_W'(1048576)) ? -TE_W'(1048576)
                                                                     : TE_W'(-dq_reg);
                            else
                                te_reg <= (dq_reg > SUM_W'(1048575)) ? TE_W'(1048575)
                                                                     : TE_W'(dq_reg);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE) xs_hold <= in_ch.x_symbol;
    end

    assign in_ch.ready             = (state_reg == ST_IDLE);
    assign out_ch.valid            = ovalid_reg;
    assign out_ch.transfer_entropy = te_reg;
    assign out_ch.too_short        = short_reg;
    assign out_ch.window_total     = total_reg;
endmodule
`default_nettype wire
